// ===== hw/rtl/clnd_pkg.sv =====
// Shared types and constants for the character LCD nibble bus driver.
package clnd_pkg;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_FUNCTION_SET    = 2'd0,
        CFG_DISPLAY_CONTROL = 2'd1,
        CFG_ENTRY_MODE      = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_idx_t;

    localparam int IDX_W        = 6;
    localparam int HOLD_W       = 13;
    localparam int INIT_PHASES  = 34;
    localparam int BYTE_PHASES  = 5;
    localparam int INIT_NIB_END = 9;

    localparam logic [HOLD_W-1:0] HOLD_POWER_ON = 13'd5000;
    localparam logic [HOLD_W-1:0] HOLD_WAKE     = 13'd2500;
    localparam logic [HOLD_W-1:0] HOLD_CMD      = 13'd1500;
    localparam logic [HOLD_W-1:0] HOLD_CLEAR    = 13'd750;
    localparam logic [HOLD_W-1:0] HOLD_CHAR     = 13'd5;
    localparam logic [HOLD_W-1:0] HOLD_STROBE   = 13'd50;
    localparam logic [HOLD_W-1:0] HOLD_NONE     = 13'd0;

    localparam logic [7:0] CMD_HOME   = 8'h02;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_LINE0  = 8'h80;
    localparam logic [7:0] CMD_LINE1  = 8'hC0;
    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [7:0] RST_FUNCTION_SET    = 8'd40;
    localparam logic [7:0] RST_DISPLAY_CONTROL = 8'd12;
    localparam logic [7:0] RST_ENTRY_MODE      = 8'd6;

    typedef struct packed {
        logic [7:0] function_set_word;
        logic [7:0] display_control_word;
        logic [7:0] entry_mode_word;
    } cfg_t;

    typedef struct packed {
        op_t              opcode;
        logic [7:0]       char_code;
        logic             line_select;
        logic [IDX_W-1:0] idx;
        logic             last;
    } item_t;

    typedef struct packed {
        logic              reg_select;
        logic              enable;
        logic [3:0]        nibble;
        logic [HOLD_W-1:0] hold_ticks;
        logic              last;
    } phase_t;

endpackage

// ===== hw/rtl/clnd_seq.sv =====
// Input register and phase counter that walks each request through its bus phases.
module clnd_seq
    import clnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] in_opcode,
    input  logic [7:0] in_char_code,
    input  logic       in_line_select,
    input  logic       take,
    output logic       step,
    output item_t      item
);

    logic             busy_reg;
    op_t              opcode_reg;
    logic [7:0]       char_reg;
    logic             line_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_idx;
    logic             is_last;

    always_comb
    begin
        if (opcode_reg == OP_INIT)
        begin
            last_idx = IDX_W'(INIT_PHASES - 1);
        end
        else
        begin
            last_idx = IDX_W'(BYTE_PHASES - 1);
        end
        is_last  = (idx_reg == last_idx);
        step     = busy_reg && take;
        s_tready = !busy_reg || (step && is_last);
        item.opcode      = opcode_reg;
        item.char_code   = char_reg;
        item.line_select = line_reg;
        item.idx         = idx_reg;
        item.last        = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (s_tvalid && s_tready)
        begin
            busy_reg <= (op_t'(in_opcode) != OP_NONE);
            idx_reg  <= '0;
        end
        else if (step)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            opcode_reg <= op_t'(in_opcode);
            char_reg   <= in_char_code;
            line_reg   <= in_line_select;
        end
    end

endmodule

// ===== hw/rtl/clnd_phase_dec.sv =====
// Combinational decode of one bus phase from the current request and phase index.
module clnd_phase_dec
    import clnd_pkg::*;
(
    input  item_t  item,
    input  cfg_t   cfg,
    output phase_t phase
);

    localparam logic [2:0] PART_SETUP   = 3'd0;
    localparam logic [2:0] PART_HI_HIGH = 3'd1;
    localparam logic [2:0] PART_HI_LOW  = 3'd2;
    localparam logic [2:0] PART_LO_HIGH = 3'd3;
    localparam logic [2:0] PART_LO_LOW  = 3'd4;

    logic              use_byte;
    logic              byte_rs;
    logic [7:0]        byte_val;
    logic [HOLD_W-1:0] byte_after;
    logic [2:0]        part;
    logic [IDX_W-1:0]  rel;
    logic [IDX_W-1:0]  nib_pos;

    always_comb
    begin
        use_byte   = 1'b0;
        byte_rs    = 1'b0;
        byte_val   = CMD_HOME;
        byte_after = HOLD_CMD;
        part       = PART_SETUP;
        rel        = item.idx - IDX_W'(INIT_NIB_END);
        nib_pos    = item.idx - IDX_W'(1);
        phase.reg_select = 1'b0;
        phase.enable     = 1'b0;
        phase.nibble     = 4'h0;
        phase.hold_ticks = HOLD_POWER_ON;
        phase.last       = item.last;

        case (item.opcode)
            OP_INIT:
            begin
                if (item.idx == '0)
                begin
                    phase.hold_ticks = HOLD_POWER_ON;
                end
                else if (item.idx < IDX_W'(INIT_NIB_END))
                begin
                    phase.enable = !nib_pos[0];
                    phase.nibble = (nib_pos[2:1] == 2'd3) ? NIB_4BIT : NIB_WAKE;
                    if (!nib_pos[0])
                    begin
                        phase.hold_ticks = HOLD_STROBE;
                    end
                    else
                    begin
                        phase.hold_ticks = (nib_pos[2:1] == 2'd3) ? HOLD_CMD : HOLD_WAKE;
                    end
                end
                else
                begin
                    use_byte = 1'b1;
                    if (rel < IDX_W'(5))
                    begin
                        byte_val = CMD_HOME;
                        part     = rel[2:0];
                    end
                    else if (rel < IDX_W'(10))
                    begin
                        byte_val = cfg.function_set_word;
                        part     = 3'(rel - IDX_W'(5));
                    end
                    else if (rel < IDX_W'(15))
                    begin
                        byte_val = cfg.display_control_word;
                        part     = 3'(rel - IDX_W'(10));
                    end
                    else if (rel < IDX_W'(20))
                    begin
                        byte_val = CMD_CLEAR;
                        part     = 3'(rel - IDX_W'(15));
                    end
                    else
                    begin
                        byte_val = cfg.entry_mode_word;
                        part     = 3'(rel - IDX_W'(20));
                    end
                end
            end
            OP_WRITE:
            begin
                use_byte = 1'b1;
                part     = item.idx[2:0];
                if (item.char_code == CHAR_FF)
                begin
                    byte_rs    = 1'b0;
                    byte_val   = CMD_CLEAR;
                    byte_after = HOLD_CLEAR;
                end
                else if (item.char_code == CHAR_LF || item.char_code == CHAR_CR)
                begin
                    byte_rs    = 1'b1;
                    byte_val   = CMD_HOME;
                    byte_after = HOLD_NONE;
                end
                else
                begin
                    byte_rs    = 1'b1;
                    byte_val   = item.char_code;
                    byte_after = HOLD_CHAR;
                end
            end
            OP_LINE:
            begin
                use_byte   = 1'b1;
                part       = item.idx[2:0];
                byte_val   = item.line_select ? CMD_LINE1 : CMD_LINE0;
                byte_after = HOLD_CHAR;
            end
            default:
            begin
                use_byte = 1'b0;
            end
        endcase

        if (use_byte)
        begin
            phase.reg_select = byte_rs;
            case (part)
                PART_SETUP:
                begin
                    phase.enable     = 1'b0;
                    phase.nibble     = 4'h0;
                    phase.hold_ticks = HOLD_STROBE;
                end
                PART_HI_HIGH:
                begin
                    phase.enable     = 1'b1;
                    phase.nibble     = byte_val[7:4];
                    phase.hold_ticks = HOLD_STROBE;
                end
                PART_HI_LOW:
                begin
                    phase.enable     = 1'b0;
                    phase.nibble     = byte_val[7:4];
                    phase.hold_ticks = HOLD_NONE;
                end
                PART_LO_HIGH:
                begin
                    phase.enable     = 1'b1;
                    phase.nibble     = byte_val[3:0];
                    phase.hold_ticks = HOLD_STROBE;
                end
                PART_LO_LOW:
                begin
                    phase.enable     = 1'b0;
                    phase.nibble     = byte_val[3:0];
                    phase.hold_ticks = HOLD_STROBE + byte_after;
                end
                default:
                begin
                    phase.enable     = 1'b0;
                    phase.nibble     = 4'h0;
                    phase.hold_ticks = HOLD_NONE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/clnd_out_reg.sv =====
// Output register that holds one bus phase until the downstream side takes it.
module clnd_out_reg
    import clnd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  phase_t phase,
    output logic   take,
    output logic   m_tvalid,
    input  logic   m_tready,
    output phase_t held
);

    logic   valid_reg;
    phase_t phase_reg;

    assign take     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign held     = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            phase_reg <= phase;
        end
    end

endmodule

// ===== hw/rtl/char_lcd_nibble_bus_driver_core.sv =====
// Top level of the character LCD nibble bus driver with its configuration registers.
// Each request expands into bus phases for a 4-bit character LCD, emitted one per clock
// from a phase counter through a single output register, unless m_tready stalls it:
// write character and move to line start give 5 phases, initialize gives 34 phases,
// and an opcode of 3 is accepted and gives none. The next request is accepted in the
// cycle in which the final phase of the current one enters the output register, so
// requests run back to back while the downstream side keeps m_tready high.
module char_lcd_nibble_bus_driver_core
    import clnd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // opcode[1:0], char_code[9:2], line_select[10], zero[15:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reg_select[0], enable[1], nibble[5:2], hold_ticks[18:6],
                                   // zero[23:19]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t   cfg_reg;
    item_t  item;
    phase_t phase;
    phase_t held;
    logic   step;
    logic   take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.function_set_word    <= RST_FUNCTION_SET;
            cfg_reg.display_control_word <= RST_DISPLAY_CONTROL;
            cfg_reg.entry_mode_word      <= RST_ENTRY_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FUNCTION_SET:    cfg_reg.function_set_word    <= cfg_data;
                CFG_DISPLAY_CONTROL: cfg_reg.display_control_word <= cfg_data;
                CFG_ENTRY_MODE:      cfg_reg.entry_mode_word      <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    clnd_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .in_opcode      (s_tdata[1:0]),
        .in_char_code   (s_tdata[9:2]),
        .in_line_select (s_tdata[10]),
        .take           (take),
        .step           (step),
        .item           (item)
    );

    clnd_phase_dec u_dec (
        .item  (item),
        .cfg   (cfg_reg),
        .phase (phase)
    );

    clnd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .phase    (phase),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    assign m_tdata = {5'd0, held.hold_ticks, held.nibble, held.enable, held.reg_select};
    assign m_tlast = held.last;

endmodule

// ===== hw/rtl/clnd_checker.sv =====
// Port-level assertions for the character LCD nibble bus driver and their binding.
module clnd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Output phase changed while stalled.");

    a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[18:6] == 13'd50)
        else $error("Enable-high phase does not hold for 50 ticks.");

    a_strobe_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tlast)
        else $error("Request ended with the enable strobe high.");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[18:6] <= 13'd55)
        else $error("Data register phase holds too long.");

endmodule

bind char_lcd_nibble_bus_driver_core clnd_checker u_clnd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
